/* hdl/rph_pkg.sv */
// package: md5 constants, message schedule and shared types for password hiding
package rph_pkg;

	localparam int SecretBytesDef = 32;
	localparam int SaltBytesDef   = 2;
	localparam int BlockBytes     = 16;
	localparam int MsgBytes       = 64;
	localparam int RoundCount     = 64;

	localparam logic [2:0] RegSecret0 = 3'd0;
	localparam logic [2:0] RegSecret1 = 3'd1;
	localparam logic [2:0] RegSecret2 = 3'd2;
	localparam logic [2:0] RegSecret3 = 3'd3;
	localparam logic [2:0] RegSecLen  = 3'd4;

	localparam logic [31:0] IvA = 32'h67452301;
	localparam logic [31:0] IvB = 32'hefcdab89;
	localparam logic [31:0] IvC = 32'h98badcfe;
	localparam logic [31:0] IvD = 32'h10325476;

	// command bundle from controller to datapath
	typedef struct packed {
		logic       load;
		logic       round;
		logic       finish;
		logic [5:0] idx;
	} rph_cmd_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_r(input logic [5:0] i);
		logic [4:0] r;
		case ({i[5:4], i[1:0]})
			4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
			4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
			4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
			4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
		endcase
		return r;
	endfunction

	// message word index for each round
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'((i[3:0] << 2) + i[3:0] + 4'd1);
			2'd2: g = 4'((i[3:0] << 1) + i[3:0] + 4'd5);
			default: g = 4'((i[3:0] << 3) - i[3:0]);
		endcase
		return g;
	endfunction

endpackage

/* hdl/radius_password_hiding_top.sv */
// top level: radius password hiding block, controller plus md5 datapath
// Each 16-byte block is loaded at acceptance, then runs 64 md5 rounds on a single round
// unit (one round a cycle), then a finish step forms the digest and xor into the result
// register, so the result is offered and held until taken. The next block is accepted
// in the cycle after the result has been taken, as the chain of each block depends on
// the one before.
module radius_password_hiding_top #(
	parameter int SECRET_BYTES = rph_pkg::SecretBytesDef,
	parameter int SALT_BYTES   = rph_pkg::SaltBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic        first_block,
	input  logic [63:0] auth_hi,
	input  logic [63:0] auth_lo,
	input  logic [15:0] salt_value,
	input  logic [1:0]  salt_len,
	input  logic [63:0] data_hi,
	input  logic [63:0] data_lo,
	input  logic        last_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo,
	output logic        result_last
);

	rph_pkg::rph_cmd_t cmd;

	rph_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
	);

	rph_dp #(.SECRET_BYTES(SECRET_BYTES), .SALT_BYTES(SALT_BYTES)) u_dp (
		.clk, .arst_n, .cmd, .cfg_we, .cfg_idx, .cfg_data, .mode, .first_block,
		.auth_hi, .auth_lo, .salt_value, .salt_len, .data_hi, .data_lo, .last_block,
		.result_hi, .result_lo, .result_last
	);

endmodule

/* hdl/rph_ctrl.sv */
// controller: sequences load, 64 md5 rounds, finish and result hand-off
module rph_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output rph_pkg::rph_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FIN   = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t     state_q;
	logic [5:0] idx_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = (state_q == ST_OUT);
	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.round  = (state_q == ST_ROUND);
	assign cmd.finish = (state_q == ST_FIN);
	assign cmd.idx    = idx_q;

	// state and round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_valid) state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'(rph_pkg::RoundCount - 1)) state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && idx_q == 6'd63) |=> state_q == ST_FIN)
		else $error("round count overrun");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");
`endif

endmodule

/* hdl/rph_dp.sv */
// datapath: message build, md5 round unit, chain register and result register
module rph_dp #(
	parameter int SECRET_BYTES = rph_pkg::SecretBytesDef,
	parameter int SALT_BYTES   = rph_pkg::SaltBytesDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rph_pkg::rph_cmd_t cmd,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [63:0]       cfg_data,
	input  logic              mode,
	input  logic              first_block,
	input  logic [63:0]       auth_hi,
	input  logic [63:0]       auth_lo,
	input  logic [15:0]       salt_value,
	input  logic [1:0]        salt_len,
	input  logic [63:0]       data_hi,
	input  logic [63:0]       data_lo,
	input  logic              last_block,
	output logic [63:0]       result_hi,
	output logic [63:0]       result_lo,
	output logic              result_last
);

	logic [SECRET_BYTES*8-1:0] secret_q;
	logic [5:0]   sec_len_q;
	logic [127:0] chain_q;
	logic [511:0] msg_q;
	logic [127:0] data_q;
	logic         mode_q;
	logic         last_q;
	logic [31:0]  a_q, b_q, c_q, d_q;

	logic [255:0] secret_full;
	logic [5:0]   slen;
	logic [1:0]   saltn;
	logic [5:0]   pos;
	logic [127:0] chain_sel;
	logic [511:0] msg_d;
	logic [31:0]  f, w, sum, rot;
	logic [4:0]   sh;
	logic [127:0] digest;
	logic [127:0] res;

	// configuration registers, only the implemented secret bytes are kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_q  <= '0;
			sec_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				rph_pkg::RegSecret0, rph_pkg::RegSecret1,
				rph_pkg::RegSecret2, rph_pkg::RegSecret3: begin
					for (int i = 0; i < SECRET_BYTES; i++) begin
						if (i / 8 == int'(cfg_idx[1:0]))
							secret_q[SECRET_BYTES*8-1-8*i -: 8] <= cfg_data[63-8*(i%8) -: 8];
					end
				end
				rph_pkg::RegSecLen: sec_len_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign secret_full = 256'(secret_q) << (256 - SECRET_BYTES*8);

	// message block: secret, chain, salt, pad byte and bit length, bytes little endian
	always_comb begin
		slen = (sec_len_q > 6'(SECRET_BYTES)) ? 6'(SECRET_BYTES) : sec_len_q;
		saltn = (salt_len > 2'(SALT_BYTES)) ? 2'(SALT_BYTES) : salt_len;
		if (!first_block) saltn = 2'd0;
		chain_sel = first_block ? {auth_hi, auth_lo} : chain_q;
		msg_d = '0;
		for (int i = 0; i < 32; i++) begin
			if (6'(i) < slen) msg_d[8*i +: 8] = secret_full[255-8*i -: 8];
		end
		for (int i = 0; i < 16; i++) begin
			msg_d[8*(int'(slen)+i) +: 8] = chain_sel[127-8*i -: 8];
		end
		pos = slen + 6'd16;
		for (int i = 0; i < 2; i++) begin
			if (2'(i) < saltn) msg_d[8*(int'(pos)+i) +: 8] = salt_value[15-8*i -: 8];
		end
		pos = pos + 6'(saltn);
		msg_d[8*int'(pos) +: 8] = 8'h80;
		msg_d[448 +: 16] = 16'({pos, 3'b000});
	end

	// one md5 round
	always_comb begin
		case (cmd.idx[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		w   = msg_q[32*rph_pkg::md5_g(cmd.idx) +: 32];
		sum = a_q + f + rph_pkg::md5_k(cmd.idx) + w;
		sh  = rph_pkg::md5_r(cmd.idx);
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
	end

	// digest bytes in message order, then xor with the data block
	always_comb begin
		logic [127:0] h;
		h = {a_q + rph_pkg::IvA, b_q + rph_pkg::IvB, c_q + rph_pkg::IvC, d_q + rph_pkg::IvD};
		for (int i = 0; i < 16; i++) begin
			digest[127-8*i -: 8] = h[96-32*(i/4) + 8*(i%4) +: 8];
		end
		res = digest ^ data_q;
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			msg_q  <= msg_d;
			data_q <= {data_hi, data_lo};
			mode_q <= mode;
			last_q <= last_block;
			a_q <= rph_pkg::IvA; b_q <= rph_pkg::IvB;
			c_q <= rph_pkg::IvC; d_q <= rph_pkg::IvD;
		end else if (cmd.round) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot;
		end
		if (cmd.finish) begin
			result_hi   <= res[127:64];
			result_lo   <= res[63:0];
			result_last <= last_q;
		end
	end

	// chain for the next block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) chain_q <= '0;
		else if (cmd.finish) chain_q <= mode_q ? res : data_q;
	end

endmodule

/* tb/radius_password_hiding_top_tb.sv */
// testbench: password hiding block against an md5-based predictor with random idling
module radius_password_hiding_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        last;
	} hidden_block_t;

	typedef struct {
		logic        mode;
		logic        first_block;
		logic [63:0] auth_hi;
		logic [63:0] auth_lo;
		logic [15:0] salt_value;
		logic [1:0]  salt_len;
		logic [63:0] data_hi;
		logic [63:0] data_lo;
		logic        last_block;
	} pw_beat_t;

	localparam int CycleLimit = 600000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic        first_block;
	logic [63:0] auth_hi;
	logic [63:0] auth_lo;
	logic [15:0] salt_value;
	logic [1:0]  salt_len;
	logic [63:0] data_hi;
	logic [63:0] data_lo;
	logic        last_block;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] result_hi;
	logic [63:0] result_lo;
	logic        result_last;

	// predictor state
	logic [63:0]   secret_words [4];
	logic [5:0]    secret_count;
	logic [63:0]   chain_hi;
	logic [63:0]   chain_lo;
	hidden_block_t expected_blocks [$];
	int            failures;
	int            cycles;
	int            burst_left;
	int            stall_mode;

	radius_password_hiding_top dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// md5 of a message of at most 55 bytes, one compression
	function automatic logic [127:0] md5_digest(input logic [7:0] msg [64], input int len);
		logic [7:0]  blk [64];
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t, sum;
		logic [63:0] bits;
		int          g, s;
		logic [127:0] dig;
		logic [31:0] h [4];
		bits = 64'(len) * 8;
		for (int i = 0; i < 64; i++) blk[i] = (i < len) ? msg[i] : 8'h00;
		blk[len] = 8'h80;
		for (int i = 0; i < 8; i++) blk[56 + i] = bits[8 * i +: 8];
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4 * i + 3], blk[4 * i + 2], blk[4 * i + 1], blk[4 * i]};
		a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = (b & c) | (~b & d); g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ c ^ d; g = (3 * i + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7 * i) % 16;
			end
			s = md5_shift(i);
			sum = a + f + md5_const(i) + w[g];
			t = d; d = c; c = b;
			b = b + ((sum << s) | (sum >> (32 - s)));
			a = t;
		end
		h[0] = 32'h67452301 + a; h[1] = 32'hefcdab89 + b;
		h[2] = 32'h98badcfe + c; h[3] = 32'h10325476 + d;
		// digest bytes little endian per word, byte 0 on top
		for (int i = 0; i < 16; i++) dig[127 - 8 * i -: 8] = h[i / 4][8 * (i % 4) +: 8];
		return dig;
	endfunction

	function automatic int md5_shift(input int i);
		int sh [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
		return sh[(i / 16) * 4 + i % 4];
	endfunction

	function automatic logic [31:0] md5_const(input int i);
		// k = floor(abs(sin(i + 1)) * 2^32)
		real v;
		v = $sin(i + 1.0);
		if (v < 0) v = -v;
		return 32'(longint'($floor(v * 4294967296.0)));
	endfunction

	// hide or reveal one block and advance the chain
	function automatic hidden_block_t hide_block(input pw_beat_t p);
		logic [7:0]   msg [64];
		logic [127:0] pad, chain;
		int           pos, slen, saltn;
		hidden_block_t r;
		slen = (secret_count > 32) ? 32 : int'(secret_count);
		for (int i = 0; i < 64; i++) msg[i] = 8'h00;
		for (int i = 0; i < slen; i++) msg[i] = secret_words[i / 8][63 - 8 * (i % 8) -: 8];
		pos = slen;
		chain = p.first_block ? {p.auth_hi, p.auth_lo} : {chain_hi, chain_lo};
		for (int i = 0; i < 16; i++) msg[pos + i] = chain[127 - 8 * i -: 8];
		pos += 16;
		if (p.first_block) begin
			saltn = (p.salt_len > 2) ? 2 : int'(p.salt_len);
			for (int i = 0; i < saltn; i++) msg[pos + i] = p.salt_value[15 - 8 * i -: 8];
			pos += saltn;
		end
		pad = md5_digest(msg, pos);
		r.hi = pad[127:64] ^ p.data_hi;
		r.lo = pad[63:0] ^ p.data_lo;
		r.last = p.last_block;
		if (p.mode) begin
			chain_hi = r.hi; chain_lo = r.lo;
		end else begin
			chain_hi = p.data_hi; chain_lo = p.data_lo;
		end
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic pw_beat_t random_beat(input logic first, input logic last);
		pw_beat_t p;
		p.mode = 1'($urandom_range(0, 1));
		p.first_block = first;
		p.auth_hi = rand64(); p.auth_lo = rand64();
		p.salt_value = 16'($urandom()); p.salt_len = 2'($urandom_range(0, 3));
		p.data_hi = rand64(); p.data_lo = rand64();
		p.last_block = last;
		return p;
	endfunction

	// register write while idle, the caller drops the write enable
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= value;
		@(posedge clk);
		if (idx < rph_pkg::RegSecLen) secret_words[idx[1:0]] = value;
		else if (idx == rph_pkg::RegSecLen) secret_count = value[5:0];
	endtask

	task automatic wait_drained();
		while (expected_blocks.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_secret(input logic [63:0] w0, w1, w2, w3, input logic [5:0] len);
		wait_drained();
		write_reg(rph_pkg::RegSecret0, w0); write_reg(rph_pkg::RegSecret1, w1);
		write_reg(rph_pkg::RegSecret2, w2); write_reg(rph_pkg::RegSecret3, w3);
		write_reg(rph_pkg::RegSecLen, 64'(len));
		// index above the register map is ignored
		write_reg(3'd5 + 3'($urandom_range(0, 2)), rand64());
		cfg_we <= 1'b0;
	endtask

	// send one beat, with bursts and gaps
	task automatic send_beat(input pw_beat_t p);
		@(posedge clk);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 6) == 0 ? $urandom_range(1, 150) : 0) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= p.mode; first_block <= p.first_block;
		auth_hi <= p.auth_hi; auth_lo <= p.auth_lo;
		salt_value <= p.salt_value; salt_len <= p.salt_len;
		data_hi <= p.data_hi; data_lo <= p.data_lo;
		last_block <= p.last_block;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_blocks.push_back(hide_block(p));
		in_valid <= 1'b0;
	endtask

	// one password of n blocks, the first and the last flagged
	task automatic send_password(input int n);
		for (int i = 0; i < n; i++) send_beat(random_beat(i == 0, i == n - 1));
	endtask

	task automatic test_directed();
		pw_beat_t p;
		set_secret('1, '1, '1, '1, 6'd63);
		// chain from reset without a first block
		p = random_beat(1'b0, 1'b0); p.data_hi = '0; p.data_lo = '0; send_beat(p);
		for (int sl = 0; sl < 4; sl++) begin
			p = random_beat(1'b1, sl[0]); p.salt_len = 2'(sl); p.mode = sl[1];
			p.salt_value = sl[0] ? 16'hffff : 16'h0000;
			p.auth_hi = sl[0] ? '1 : '0; p.auth_lo = p.auth_hi;
			p.data_hi = sl[1] ? '1 : '0; p.data_lo = ~p.data_hi;
			send_beat(p);
		end
		set_secret('0, '0, '0, '0, 6'd0);
		send_password(3);
		p = random_beat(1'b0, 1'b1); p.mode = 1'b0; send_beat(p);
		set_secret(rand64(), rand64(), rand64(), rand64(), 6'd32);
		send_password(4);
		set_secret(rand64(), rand64(), rand64(), rand64(), 6'd33);
		send_password(2);
		set_secret(rand64(), 64'h0, 64'h0, 64'h0, 6'd1);
		send_password(2);
	endtask

	task automatic test_random();
		int n;
		n = 0;
		for (int phase = 0; phase < 6; phase++) begin
			set_secret(rand64(), rand64(), rand64(), rand64(),
				phase == 0 ? 6'd32 : 6'($urandom_range(0, 63)));
			while (n < 200 * (phase + 1)) begin
				if ($urandom_range(0, 9) == 0) begin
					send_beat(random_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
					n++;
				end else begin
					int len;
					len = $urandom_range(1, 8);
					send_password(len);
					n += len;
				end
				// sender hold-off until all results are back
				if ($urandom_range(0, 40) == 0)
					while (expected_blocks.size() != 0) @(posedge clk);
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		hidden_block_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_blocks.size() == 0) begin
				$error("unexpected result beat");
				failures++;
			end else begin
				e = expected_blocks.pop_front();
				if (result_hi !== e.hi) begin
					$error("result_hi expected %h actual %h", e.hi, result_hi);
					failures++;
				end
				if (result_lo !== e.lo) begin
					$error("result_lo expected %h actual %h", e.lo, result_lo);
					failures++;
				end
				if (result_last !== e.last) begin
					$error("result_last expected %b actual %b", e.last, result_last);
					failures++;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (cycles % 3000 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		failures = 0; cycles = 0; burst_left = 0; stall_mode = 0;
		chain_hi = '0; chain_lo = '0; secret_count = '0;
		for (int i = 0; i < 4; i++) secret_words[i] = '0;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
		in_valid = 1'b0; out_stall = 1'b0;
		mode = 1'b0; first_block = 1'b0; auth_hi = '0; auth_lo = '0;
		salt_value = '0; salt_len = '0; data_hi = '0; data_lo = '0; last_block = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		wait_drained();
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
